### sv/pdmhc_pkg.sv
// package for the per-domain minute hit counter
// holds the transfer structs, the sequencer states, the division constants and the hash helpers
// no dependencies
`default_nettype none

package pdmhc_pkg;

	// fixed geometry
	localparam int MINUTE_BUCKETS       = 60;
	localparam int DEFAULT_DOMAIN_SLOTS = 16;

	// now / 3600 as ((now >> 4) * HOUR_DIV_MUL) >> HOUR_DIV_SHIFT, exact for 28-bit operands
	localparam logic [28:0] HOUR_DIV_MUL     = 29'd305419897;
	localparam int          HOUR_DIV_SHIFT   = 36;
	localparam logic [11:0] SECONDS_PER_HOUR = 12'd3600;

	// r / 60 as (r * MINUTE_DIV_MUL) >> MINUTE_DIV_SHIFT, exact for r below 4096
	localparam logic [14:0] MINUTE_DIV_MUL   = 15'd17477;
	localparam int          MINUTE_DIV_SHIFT = 20;

	// input transfer
	typedef struct packed {
		logic [7:0]  name_byte;
		logic        byte_valid;
		logic        last_byte;
		logic [31:0] now_seconds;
	} in_item_t;

	// result transfer
	typedef struct packed {
		logic [3:0]  slot_index;
		logic [5:0]  minute_bucket;
		logic [31:0] bucket_count;
		logic        table_full;
	} out_item_t;

	// one domain slot row
	typedef struct packed {
		logic [31:0] domain_hash;
		logic [5:0]  cur_bucket;
	} slot_row_t;

	// one bucket row
	typedef struct packed {
		logic [31:0] last_time;
		logic [31:0] count;
	} cnt_row_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FINISH,
		ST_SCAN,
		ST_LOOKUP,
		ST_UPDATE
	} pdmhc_state_t;

	// one-at-a-time hash, per-byte mixing step
	function automatic logic [31:0] fold_byte(input logic [31:0] h, input logic [7:0] b);
		logic [31:0] t;
		t = h + {24'd0, b};
		t = t + (t << 10);
		t = t ^ (t >> 6);
		return t;
	endfunction

	// one-at-a-time hash, final avalanche
	function automatic logic [31:0] finish_hash(input logic [31:0] h);
		logic [31:0] t;
		t = h + (h << 3);
		t = t ^ (t >> 11);
		t = t + (t << 15);
		return t;
	endfunction

endpackage

`default_nettype wire

### sv/per_domain_minute_hit_counter.sv
// per-domain minute hit counter, top level
// depends on pdmhc_pkg (transfer structs, states, division constants, hash functions)
// holds the slot memory, the bucket memory and the update sequencer
`default_nettype none

// Name bytes are folded into a one-at-a-time hash at one byte per cycle while the sequencer
// is idle. The end-of-name transfer starts a sequence: a step to finalise the hash, a scan of
// the slot memory that reads one slot per cycle until a slot matches or is free or the table
// is found full, a read of the bucket memory unless the table is full, and last the load of
// the result register together with the bucket write back when a slot was found. The input is
// held off for the whole sequence, whose length the one-port slot scan sets. The minute of the
// hour is worked out by reciprocal multiplication in a three-stage pipeline alongside the scan.
// After reset the bucket memory is cleared one entry per cycle, with the input held off. A
// result may wait in the output register while new name bytes are taken.
module per_domain_minute_hit_counter #(
	parameter int DOMAIN_SLOTS = pdmhc_pkg::DEFAULT_DOMAIN_SLOTS
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       in_valid,
	output logic                      in_ready,
	input  wire pdmhc_pkg::in_item_t  in_item,
	output logic                      out_valid,
	input  wire                       out_ready,
	output pdmhc_pkg::out_item_t      out_item
);

	localparam int SLOT_W = (DOMAIN_SLOTS > 1) ? $clog2(DOMAIN_SLOTS) : 1;
	localparam int CELLS  = DOMAIN_SLOTS * pdmhc_pkg::MINUTE_BUCKETS;
	localparam int CELL_W = $clog2(CELLS);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(DOMAIN_SLOTS - 1);
	localparam logic [CELL_W-1:0] LAST_CELL = CELL_W'(CELLS - 1);

	// memories
	pdmhc_pkg::slot_row_t slot_mem [DOMAIN_SLOTS];
	pdmhc_pkg::cnt_row_t  cnt_mem  [CELLS];

	// control state
	pdmhc_pkg::pdmhc_state_t state_q, state_d;
	logic [31:0]             hash_q;
	logic [CELL_W-1:0]       clr_q;
	logic [DOMAIN_SLOTS-1:0] slot_vld_q;
	logic [SLOT_W-1:0]       rd_idx_q;
	logic                    chk_vld_s1;
	logic                    out_valid_q;

	// payload registers
	logic [31:0]             now_q;
	logic [31:0]             key_q;
	logic [SLOT_W-1:0]       chk_idx_s1;
	pdmhc_pkg::slot_row_t    slot_rd_s1;
	logic                    slot_rd_vld_s1;
	logic [SLOT_W-1:0]       slot_q;
	logic [5:0]              cur_bucket_q;
	logic                    full_q;
	logic [CELL_W-1:0]       cell_q;
	pdmhc_pkg::cnt_row_t     cnt_rd_s1;
	pdmhc_pkg::out_item_t    out_q;

	// minute pipeline
	logic [11:0]             hour_quot_s1;
	logic [11:0]             hour_rem_s2;
	logic [25:0]             min_prod_s3;

	// sequencer outputs
	logic                    slot_re;
	logic                    cnt_re;
	logic                    cnt_we;
	logic                    out_load;

	// datapath nets
	logic                    in_xfer;
	logic [31:0]             hash_next;
	logic [56:0]             hour_prod;
	logic [5:0]              bucket;
	logic [31:0]             row_hash;
	logic                    slot_hit;
	logic [CELL_W-1:0]       cell_d;
	logic                    clear_cnt;
	logic [31:0]             old_count;
	logic [31:0]             new_count;
	logic [8:0]              slot_wide;
	logic [CELL_W-1:0]       cnt_wa;
	pdmhc_pkg::cnt_row_t     cnt_wd;
	pdmhc_pkg::out_item_t    out_d;

	assign in_xfer = in_valid & in_ready;

	// hash of the bytes so far plus the byte of this transfer
	assign hash_next = in_item.byte_valid ? pdmhc_pkg::fold_byte(hash_q, in_item.name_byte)
	                                      : hash_q;

	// minute of the hour: (now mod 3600) / 60 by reciprocal multiplication
	assign hour_prod = 57'(now_q[31:4]) * 57'(pdmhc_pkg::HOUR_DIV_MUL);
	assign bucket    = min_prod_s3[pdmhc_pkg::MINUTE_DIV_SHIFT +: 6];

	always_ff @(posedge clk) begin
		hour_quot_s1 <= hour_prod[pdmhc_pkg::HOUR_DIV_SHIFT +: 12];
		hour_rem_s2  <= now_q[11:0]
		              - 12'(24'(hour_quot_s1) * 24'(pdmhc_pkg::SECONDS_PER_HOUR));
		min_prod_s3  <= 26'(hour_rem_s2) * 26'(pdmhc_pkg::MINUTE_DIV_MUL);
	end

	// slot compare: an unwritten slot reads as empty
	assign row_hash = slot_rd_vld_s1 ? slot_rd_s1.domain_hash : 32'd0;
	assign slot_hit = (row_hash == 32'd0) || (row_hash == key_q);

	// bucket address and count update
	assign cell_d    = CELL_W'(slot_q) * CELL_W'(pdmhc_pkg::MINUTE_BUCKETS) + CELL_W'(bucket);
	assign clear_cnt = (cur_bucket_q != 6'd0) && (cur_bucket_q != bucket);
	assign old_count = clear_cnt ? 32'd0 : cnt_rd_s1.count;
	assign new_count = (old_count == 32'hFFFF_FFFF) ? old_count : old_count + 32'd1;
	assign slot_wide = 9'(slot_q);

	// result assembly
	always_comb begin
		out_d.minute_bucket = bucket;
		out_d.table_full    = full_q;
		if (full_q) begin
			out_d.slot_index   = 4'd0;
			out_d.bucket_count = 32'd0;
		end else begin
			out_d.slot_index   = slot_wide[3:0];
			out_d.bucket_count = new_count;
		end
	end

	// sequencer: next state and strobes
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		slot_re  = 1'b0;
		cnt_re   = 1'b0;
		cnt_we   = 1'b0;
		out_load = 1'b0;
		case (state_q)
			pdmhc_pkg::ST_CLEAR: begin
				cnt_we = 1'b1;
				if (clr_q == LAST_CELL) begin
					state_d = pdmhc_pkg::ST_IDLE;
				end
			end
			pdmhc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && in_item.last_byte) begin
					state_d = pdmhc_pkg::ST_FINISH;
				end
			end
			pdmhc_pkg::ST_FINISH: begin
				state_d = pdmhc_pkg::ST_SCAN;
			end
			pdmhc_pkg::ST_SCAN: begin
				slot_re = 1'b1;
				if (chk_vld_s1) begin
					if (slot_hit) begin
						state_d = pdmhc_pkg::ST_LOOKUP;
					end else if (chk_idx_s1 == LAST_SLOT) begin
						state_d = pdmhc_pkg::ST_UPDATE;
					end
				end
			end
			pdmhc_pkg::ST_LOOKUP: begin
				cnt_re  = 1'b1;
				state_d = pdmhc_pkg::ST_UPDATE;
			end
			pdmhc_pkg::ST_UPDATE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					cnt_we   = !full_q;
					state_d  = pdmhc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pdmhc_pkg::ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pdmhc_pkg::ST_CLEAR;
			hash_q      <= 32'd0;
			clr_q       <= '0;
			slot_vld_q  <= '0;
			rd_idx_q    <= '0;
			chk_vld_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			chk_vld_s1 <= slot_re;
			if (state_q == pdmhc_pkg::ST_CLEAR) begin
				clr_q <= clr_q + CELL_W'(1);
			end
			// running hash: fold on transfer, back to zero once finalised
			if (in_xfer && !in_item.last_byte) begin
				hash_q <= hash_next;
			end else if (state_q == pdmhc_pkg::ST_FINISH) begin
				hash_q <= 32'd0;
			end
			// scan read pointer, held on the last slot
			if (state_q == pdmhc_pkg::ST_FINISH) begin
				rd_idx_q <= '0;
			end else if (slot_re && rd_idx_q != LAST_SLOT) begin
				rd_idx_q <= rd_idx_q + SLOT_W'(1);
			end
			if (out_load && !full_q) begin
				slot_vld_q[slot_q] <= 1'b1;
			end
			// result register
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_xfer && in_item.last_byte) begin
			now_q  <= in_item.now_seconds;
			key_q  <= hash_next;
		end else if (state_q == pdmhc_pkg::ST_FINISH) begin
			key_q  <= pdmhc_pkg::finish_hash(key_q);
		end
		chk_idx_s1 <= rd_idx_q;
		if (state_q == pdmhc_pkg::ST_SCAN && chk_vld_s1) begin
			slot_q       <= chk_idx_s1;
			cur_bucket_q <= slot_rd_vld_s1 ? slot_rd_s1.cur_bucket : 6'd0;
			full_q       <= !slot_hit;
		end
		if (cnt_re) begin
			cell_q <= cell_d;
		end
		if (out_load) begin
			out_q <= out_d;
		end
	end

	// slot memory: scan read, write back on update
	always_ff @(posedge clk) begin
		if (slot_re) begin
			slot_rd_s1     <= slot_mem[rd_idx_q];
			slot_rd_vld_s1 <= slot_vld_q[rd_idx_q];
		end
		if (out_load && !full_q) begin
			slot_mem[slot_q] <= '{domain_hash: key_q, cur_bucket: bucket};
		end
	end

	// bucket memory: clearing pass after reset, then read-modify-write
	assign cnt_wa = (state_q == pdmhc_pkg::ST_CLEAR) ? clr_q : cell_q;
	always_comb begin
		if (state_q == pdmhc_pkg::ST_CLEAR) begin
			cnt_wd = '0;
		end else begin
			cnt_wd.last_time = now_q;
			cnt_wd.count     = new_count;
		end
	end

	always_ff @(posedge clk) begin
		if (cnt_re) begin
			cnt_rd_s1 <= cnt_mem[cell_d];
		end
		if (cnt_we) begin
			cnt_mem[cnt_wa] <= cnt_wd;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// a full-table result carries neither slot nor count
	a_full_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.table_full |->
			out_item.bucket_count == 32'd0 && out_item.slot_index == 4'd0)
		else $error("table-full result with slot or count set");

	// an update always leaves a nonzero count
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.table_full |-> out_item.bucket_count != 32'd0)
		else $error("updated bucket reports a zero count");

	// minute of the hour stays in range
	a_bucket_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.minute_bucket < 6'd60)
		else $error("minute bucket out of range");

	// the result register is only reloaded once the previous result has gone
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !out_valid_q || out_ready)
		else $error("result register overwritten before transfer");

endmodule

`default_nettype wire

### bench/pdmhc_checker.sv
// result checker for the per-domain minute hit counter
// watches both channels, predicts every end-of-name result and compares it field by field
// depends on pdmhc_pkg for the transfer structs
module pdmhc_checker #(
	parameter int DOMAIN_SLOTS = pdmhc_pkg::DEFAULT_DOMAIN_SLOTS
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	input  wire                  in_ready,
	input  pdmhc_pkg::in_item_t  in_item,
	input  wire                  out_valid,
	input  wire                  out_ready,
	input  pdmhc_pkg::out_item_t out_item,
	output int                   errors,
	output int                   pending,
	output int                   names_seen,
	output int                   full_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_REPORTS = 10;
	localparam int CELLS       = DOMAIN_SLOTS * pdmhc_pkg::MINUTE_BUCKETS;

	// predicted block state
	logic [31:0] name_hash;
	logic [31:0] slot_hash   [DOMAIN_SLOTS];
	logic [5:0]  slot_minute [DOMAIN_SLOTS];
	logic [31:0] hits        [CELLS];

	// results still owed by the block, oldest first
	pdmhc_pkg::out_item_t due_q [$];
	int          bad;
	int          names;
	int          fulls;

	// per-byte mixing of the running name hash
	function automatic logic [31:0] hash_fold_byte(input logic [31:0] acc, input logic [7:0] b);
		logic [31:0] v;
		v = acc + {24'd0, b};
		v = v + (v << 10);
		return v ^ (v >> 6);
	endfunction

	// closing avalanche applied at the end of a name
	function automatic logic [31:0] hash_avalanche(input logic [31:0] acc);
		logic [31:0] v;
		v = acc + (acc << 3);
		v = v ^ (v >> 11);
		return v + (v << 15);
	endfunction

	always @(posedge clk) begin : watch
		pdmhc_pkg::out_item_t want;
		logic [31:0] h;
		logic [5:0]  minute;
		int          slot;
		int          cnt_idx;
		if (!arst_n) begin
			name_hash = '0;
			for (int s = 0; s < DOMAIN_SLOTS; s++) begin
				slot_hash[s]   = '0;
				slot_minute[s] = '0;
			end
			for (int c = 0; c < CELLS; c++)
				hits[c] = '0;
			due_q.delete();
			bad   = 0;
			names = 0;
			fulls = 0;
		end else begin
			// result transfer against the oldest expectation
			if (out_valid && out_ready) begin
				if (due_q.size() == 0) begin
					bad++;
					if (bad <= MAX_REPORTS)
						$display("%0t: result with none expected: slot %0d minute %0d count %0d full %0b",
							$realtime, out_item.slot_index, out_item.minute_bucket,
							out_item.bucket_count, out_item.table_full);
				end else begin
					want = due_q.pop_front();
					if (out_item.slot_index !== want.slot_index ||
							out_item.minute_bucket !== want.minute_bucket ||
							out_item.bucket_count !== want.bucket_count ||
							out_item.table_full !== want.table_full) begin
						bad++;
						if (bad <= MAX_REPORTS)
							$display("%0t: mismatch slot %0d/%0d minute %0d/%0d count %0d/%0d full %0b/%0b",
								$realtime, out_item.slot_index, want.slot_index,
								out_item.minute_bucket, want.minute_bucket,
								out_item.bucket_count, want.bucket_count,
								out_item.table_full, want.table_full);
					end
				end
			end

			// name transfer: fold the byte, and on the end mark update the table
			if (in_valid && in_ready) begin
				if (in_item.byte_valid)
					name_hash = hash_fold_byte(name_hash, in_item.name_byte);
				if (in_item.last_byte) begin
					h         = hash_avalanche(name_hash);
					name_hash = '0;
					minute    = 6'((in_item.now_seconds % 32'd3600) / 32'd60);
					slot      = -1;
					for (int s = 0; s < DOMAIN_SLOTS; s++)
						if (slot < 0 && (slot_hash[s] == '0 || slot_hash[s] == h))
							slot = s;
					want = '0;
					want.minute_bucket = minute;
					if (slot < 0) begin
						want.table_full = 1'b1;
						fulls++;
					end else begin
						cnt_idx = slot * pdmhc_pkg::MINUTE_BUCKETS + int'(minute);
						slot_hash[slot] = h;
						// a stored minute of zero is taken as unset
						if (slot_minute[slot] == '0)
							slot_minute[slot] = minute;
						if (slot_minute[slot] != minute) begin
							hits[cnt_idx]     = '0;
							slot_minute[slot] = minute;
						end
						if (hits[cnt_idx] != '1)
							hits[cnt_idx] = hits[cnt_idx] + 32'd1;
						want.slot_index   = 4'(slot);
						want.bucket_count = hits[cnt_idx];
					end
					due_q.push_back(want);
					names++;
				end
			end
		end
		errors     <= bad;
		pending    <= due_q.size();
		names_seen <= names;
		full_seen  <= fulls;
	end

endmodule

### bench/testbench.sv
// top of the per-domain minute hit counter bench: clock, reset, stimulus and verdict
// depends on pdmhc_pkg, per_domain_minute_hit_counter and pdmhc_checker
// drives names from a small pool so slots fill up, counts grow and the table runs full
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS        = pdmhc_pkg::DEFAULT_DOMAIN_SLOTS;
	localparam int POOL         = 18;
	localparam int SCRATCH      = POOL;
	localparam int MAX_LEN      = 6;
	localparam int PHASE_ITEMS  = 165;
	localparam int QUIET_LIMIT  = 10000;
	localparam int DRAIN_CYCLES = SLOTS + 24;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	pdmhc_pkg::in_item_t  in_item   = '0;
	logic                 out_ready = 1'b0;
	logic                 in_ready;
	logic                 out_valid;
	pdmhc_pkg::out_item_t out_item;

	int errors;
	int pending;
	int names_seen;
	int full_seen;

	// idling knobs, percent of cycles
	int idle_pct  = 0;
	int stall_pct = 0;
	int idle_plan [4] = '{0, 85, 0, 29};
	int stall_plan[4] = '{0, 0, 85, 29};

	// name pool, last row is scratch for fresh and cut-short names
	logic [7:0]  name_bytes [POOL + 1][MAX_LEN];
	int          name_len   [POOL + 1];
	int          fed = 0;
	logic [31:0] wall;
	int          quiet = 0;

	per_domain_minute_hit_counter #(.DOMAIN_SLOTS(SLOTS)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

	pdmhc_checker #(.DOMAIN_SLOTS(SLOTS)) chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.errors    (errors),
		.pending   (pending),
		.names_seen(names_seen),
		.full_seen (full_seen)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver back-pressure
	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= stall_pct);

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet == QUIET_LIMIT) begin
				$display("testbench NOT OK");
				$finish;
			end
		end
	end

	function automatic pdmhc_pkg::in_item_t make_item(input logic [7:0] b, input logic v,
			input logic l, input logic [31:0] t);
		pdmhc_pkg::in_item_t it;
		it.name_byte   = b;
		it.byte_valid  = v;
		it.last_byte   = l;
		it.now_seconds = t;
		return it;
	endfunction

	// one input transfer, entered and left at a falling edge
	task automatic put_item(input pdmhc_pkg::in_item_t it);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// byte with no meaning for the hash
	task automatic put_noise(input int noise_pct);
		if ($urandom_range(99) < noise_pct)
			put_item(make_item(8'($urandom_range(255)), 1'b0, 1'b0, $urandom()));
	endtask

	// whole name; the last byte rides on the end transfer or a separate empty end follows
	task automatic send_name(input int idx, input logic [31:0] stamp, input bit tail_in_end,
			input int noise_pct);
		int n;
		bit tail;
		n    = name_len[idx];
		tail = tail_in_end && n > 0;
		for (int k = 0; k < n; k++) begin
			if (tail && k == n - 1)
				break;
			put_noise(noise_pct);
			put_item(make_item(name_bytes[idx][k], 1'b1, 1'b0, $urandom()));
			fed++;
		end
		put_noise(noise_pct);
		if (tail)
			put_item(make_item(name_bytes[idx][n - 1], 1'b1, 1'b1, stamp));
		else
			put_item(make_item(8'($urandom_range(255)), 1'b0, 1'b1, stamp));
		fed++;
	endtask

	// hold the sender until every result is back, then switch idling
	task automatic drain_then(input int next_idle, input int next_stall);
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		idle_pct  = next_idle;
		stall_pct = next_stall;
		@(negedge clk);
	endtask

	initial begin
		int pick;
		int src;
		int target;
		// pool of short names, first two at the byte extremes
		for (int p = 0; p < POOL; p++) begin
			name_len[p] = $urandom_range(1, MAX_LEN);
			for (int k = 0; k < MAX_LEN; k++)
				name_bytes[p][k] = 8'($urandom_range(255));
		end
		name_len[0]      = 1;
		name_bytes[0][0] = 8'h00;
		name_len[1]      = 1;
		name_bytes[1][0] = 8'hFF;
		name_len[SCRATCH] = 0;

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// directed: empty name hashes to zero and leaves slot 0 looking empty
		send_name(SCRATCH, 32'd0, 1'b0, 0);
		// same minute, unset minute, minute changes back and forth
		send_name(0, 32'd0, 1'b1, 0);
		send_name(0, 32'd59, 1'b0, 100);
		send_name(0, 32'd60, 1'b1, 0);
		send_name(0, 32'd3599, 1'b0, 0);
		send_name(0, 32'd60, 1'b1, 0);
		// top byte value and time at its top
		send_name(1, 32'hFFFF_FFFF, 1'b1, 0);
		send_name(1, 32'hFFFF_FFFF, 1'b0, 100);
		// empty name again lands on the next free slot
		send_name(SCRATCH, 32'd3600, 1'b0, 0);
		send_name(2, 32'd7260, 1'b0, 100);
		send_name(2, 32'd7261, 1'b1, 0);
		wall = 32'd3000;

		// random names in four idling phases, sender held for all results in between
		for (int ph = 0; ph < 4; ph++) begin
			drain_then(idle_plan[ph], stall_plan[ph]);
			target = fed + PHASE_ITEMS;
			while (fed < target) begin
				pick = $urandom_range(99);
				if (pick < 8) begin
					// fresh name, possibly empty
					name_len[SCRATCH] = $urandom_range(0, MAX_LEN);
					for (int k = 0; k < MAX_LEN; k++)
						name_bytes[SCRATCH][k] = 8'($urandom_range(255));
					send_name(SCRATCH, wall, 1'($urandom_range(1)), 10);
				end else if (pick < 13) begin
					// name cut short
					src = $urandom_range(POOL - 1);
					name_len[SCRATCH] = $urandom_range(0, name_len[src] - 1);
					for (int k = 0; k < MAX_LEN; k++)
						name_bytes[SCRATCH][k] = name_bytes[src][k];
					send_name(SCRATCH, wall, 1'($urandom_range(1)), 10);
				end else begin
					send_name($urandom_range(POOL - 1), wall, 1'($urandom_range(1)), 10);
				end
				if ($urandom_range(99) < 3)
					wall = $urandom();
				else
					wall = wall + 32'($urandom_range(0, 40));
			end
		end

		drain_then(0, 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d names over %0d counted transfers, %0d of them against a full table",
			names_seen, fed, full_seen);
		$display("idling phases: none, sender 85%%, receiver 85%%, both 29%%");
		if (errors == 0 && pending == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
